>>> rtl/ddct_pkg.sv
// ----------------------------------------------------------------------------
// Differential-drive computed-torque package
// Shared word types, register codes, reset values and helper functions.
// ----------------------------------------------------------------------------
package ddct_pkg;

   // Default number of fraction bits of the Q values other than the gain entries.
   localparam int FracBitsDefault = 16;

   // Fraction bits of the Q8.8 gain entries.
   localparam int GainFrac = 8;

   // Width of the register index on the configuration port.
   localparam int CsrIndexW = 4;

   // Actuator matrix entries R/W and R with 32 fraction bits.
   localparam logic [63:0] KRwQ32 = 64'd1918476337;
   localparam logic [63:0] KRQ32  = 64'd953482740;

   typedef enum logic [CsrIndexW-1:0] {
      REG_KP_GAINS         = 4'd0,
      REG_KV_GAINS         = 4'd1,
      REG_BASE_MASS        = 4'd2,
      REG_BASE_INERTIA     = 4'd3,
      REG_INVERSE_MASS     = 4'd4,
      REG_INVERSE_INERTIA  = 4'd5,
      REG_FRICTION_LINEAR  = 4'd6,
      REG_FRICTION_ANGULAR = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [63:0] kp_gains;
      logic [63:0] kv_gains;
      logic [31:0] base_mass;
      logic [31:0] base_inertia;
      logic [31:0] inverse_mass;
      logic [31:0] inverse_inertia;
      logic [31:0] friction_linear;
      logic [31:0] friction_angular;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      kp_gains:         64'd0,
      kv_gains:         64'd0,
      base_mass:        32'd786432,
      base_inertia:     32'd40130,
      inverse_mass:     32'd5461,
      inverse_inertia:  32'd107021,
      friction_linear:  32'd1245,
      friction_angular: 32'd4981
   };

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] pos_error;
      logic signed [31:0] heading_error;
      logic signed [31:0] lin_vel_error;
      logic signed [31:0] ang_vel_error;
      logic signed [31:0] lin_accel_ref;
      logic signed [31:0] ang_accel_ref;
      logic signed [31:0] lin_vel;
      logic signed [31:0] ang_vel;
      logic signed [31:0] torque_first;
      logic signed [31:0] torque_second;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] result_first;
      logic signed [31:0] result_second;
      logic               saturated;
   } rsp_word_type;

   // Rounds a constant with 32 fraction bits to the given number of fraction bits.
   function automatic logic [63:0] round_coef(input logic [63:0] q32, input int frac);
      logic [63:0] half;
      half = 64'd1 << (31 - frac);
      return (q32 + half) >> (32 - frac);
   endfunction

   // Clips to the signed 32-bit range. Bit 32 of the result flags a clip.
   function automatic logic [32:0] sat32(input logic signed [65:0] x);
      logic [32:0] res;
      if (x > 66'sd2147483647) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (x < -66'sd2147483648) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, x[31:0]};
      end
      return res;
   endfunction

endpackage

>>> rtl/ddct_csr.sv
// ----------------------------------------------------------------------------
// Computed-torque configuration registers
// Holds the gain matrices and the dynamic coefficients of the base.
// ----------------------------------------------------------------------------
module ddct_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ddct_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [63:0]                     csr_wdata,
   output ddct_pkg::cfg_type               cfg
);
   import ddct_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_KP_GAINS:         cfg_in.kp_gains         = csr_wdata;
            REG_KV_GAINS:         cfg_in.kv_gains         = csr_wdata;
            REG_BASE_MASS:        cfg_in.base_mass        = csr_wdata[31:0];
            REG_BASE_INERTIA:     cfg_in.base_inertia     = csr_wdata[31:0];
            REG_INVERSE_MASS:     cfg_in.inverse_mass     = csr_wdata[31:0];
            REG_INVERSE_INERTIA:  cfg_in.inverse_inertia  = csr_wdata[31:0];
            REG_FRICTION_LINEAR:  cfg_in.friction_linear  = csr_wdata[31:0];
            REG_FRICTION_ANGULAR: cfg_in.friction_angular = csr_wdata[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/diff_drive_computed_torque.sv
// ----------------------------------------------------------------------------
// Differential-drive computed-torque unit
// Six-stage fixed-point pipeline for the control law and forward dynamics.
// ----------------------------------------------------------------------------
// This unit takes one request word per clock cycle while req_stall is low
// and returns one response word for each, in order, from the output
// register of the last stage. With cmd clear it computes the right and left
// wheel torques of the computed-torque law, and with cmd set it computes
// the forward-dynamics linear and angular accelerations; saturated reports
// any clip to the 32-bit range along the way. Without a response stall,
// throughput is one word per cycle, set by the six register stages that
// each hold at most one multiplier rank or one wide add with rounding and
// clipping. A stall on the response side holds the output register, and
// earlier stages keep filling bubbles, so req_stall only rises once every
// stage holds a word. Configuration writes are taken in any cycle but must
// only be issued while the pipeline is empty.
module diff_drive_computed_torque #(
   parameter int FRAC_BITS = ddct_pkg::FracBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ddct_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ddct_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ddct_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [63:0]                     csr_wdata
);
   import ddct_pkg::*;

   localparam int NumStages = 6;
   // Width of a rescaled coefficient product.
   localparam int CvW  = 64 - FRAC_BITS;
   // Width of an actuator product.
   localparam int ActW = 33 + FRAC_BITS;

   localparam logic [FRAC_BITS-1:0] KRw = FRAC_BITS'(round_coef(KRwQ32, FRAC_BITS));
   localparam logic [FRAC_BITS-1:0] KR  = FRAC_BITS'(round_coef(KRQ32, FRAC_BITS));

   localparam logic signed [64:0]     HalfQ = 65'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [ActW-1:0] HalfA = ActW'(HalfQ);
   localparam logic signed [51:0]     HalfG = 52'sd1 <<< (GainFrac - 1);

   cfg_type cfg;

   ddct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Component 0 is the linear entry of each input pair and meets the yaw
   // inertia terms; component 1 is the angular entry and meets the mass terms.
   logic [31:0] m_diag [2];
   logic [31:0] c_diag [2];
   logic [31:0] i_diag [2];

   assign m_diag[0] = cfg.base_inertia;
   assign m_diag[1] = cfg.base_mass;
   assign c_diag[0] = cfg.friction_angular;
   assign c_diag[1] = cfg.friction_linear;
   assign i_diag[0] = cfg.inverse_inertia;
   assign i_diag[1] = cfg.inverse_mass;

   // ------------------------------------------------------------------------
   // Flow control. A stage loads when it is empty or when the stage after it
   // loads, so a stall only backs up as far as the nearest bubble.
   // ------------------------------------------------------------------------
   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages:0]   ld;

   always_comb begin
      ld[NumStages] = !rsp_stall;
      for (int k = NumStages - 1; k >= 0; k--) begin
         ld[k] = !valid_ff[k] || ld[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NumStages; k++) begin
         if (k == 0) begin
            valid_in[k] = ld[k] ? req_valid : valid_ff[k];
         end else begin
            valid_in[k] = ld[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ld[0];
   assign rsp_valid = valid_ff[NumStages-1];

   // ------------------------------------------------------------------------
   // Stage 1: gain products and the friction products.
   // ------------------------------------------------------------------------
   logic signed [31:0] ep [2];
   logic signed [31:0] ev [2];
   logic signed [31:0] vel [2];

   assign ep[0]  = req_word.pos_error;
   assign ep[1]  = req_word.heading_error;
   assign ev[0]  = req_word.lin_vel_error;
   assign ev[1]  = req_word.ang_vel_error;
   assign vel[0] = req_word.lin_vel;
   assign vel[1] = req_word.ang_vel;

   logic               s1_cmd_ff, s1_cmd_in;
   logic signed [47:0] s1_gp_ff [2][4];
   logic signed [47:0] s1_gp_in [2][4];
   logic signed [31:0] s1_ar_ff [2];
   logic signed [31:0] s1_ar_in [2];
   logic signed [31:0] s1_tq_ff [2];
   logic signed [31:0] s1_tq_in [2];
   logic signed [63:0] s1_cvp_ff [2];
   logic signed [63:0] s1_cvp_in [2];

   always_comb begin
      s1_cmd_in   = req_word.cmd;
      s1_ar_in[0] = req_word.lin_accel_ref;
      s1_ar_in[1] = req_word.ang_accel_ref;
      s1_tq_in[0] = req_word.torque_first;
      s1_tq_in[1] = req_word.torque_second;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            s1_gp_in[i][j] =
               48'(signed'(cfg.kv_gains[16*(2*i+j) +: 16])) * 48'(ev[j]);
            s1_gp_in[i][2+j] =
               48'(signed'(cfg.kp_gains[16*(2*i+j) +: 16])) * 48'(ep[j]);
         end
         s1_cvp_in[i] = 64'(signed'({1'b0, c_diag[i]})) * 64'(vel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s1_cmd_ff <= s1_cmd_in;
         s1_gp_ff  <= s1_gp_in;
         s1_ar_ff  <= s1_ar_in;
         s1_tq_ff  <= s1_tq_in;
         s1_cvp_ff <= s1_cvp_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: gain sums rounded to Q values, friction terms rounded, and the
   // net force for forward dynamics.
   // ------------------------------------------------------------------------
   logic signed [51:0]  s2_acc [2];
   logic signed [51:0]  s2_rnd [2];
   logic signed [64:0]  s2_cvr [2];
   logic [1:0]          s2_ssat;
   logic [1:0]          s2_dsat;

   logic                s2_cmd_ff, s2_cmd_in;
   logic                s2_flag_ff, s2_flag_in;
   logic signed [31:0]  s2_s_ff [2];
   logic signed [31:0]  s2_s_in [2];
   logic signed [31:0]  s2_d_ff [2];
   logic signed [31:0]  s2_d_in [2];
   logic signed [CvW-1:0] s2_cv_ff [2];
   logic signed [CvW-1:0] s2_cv_in [2];

   always_comb begin
      s2_cmd_in = s1_cmd_ff;
      for (int i = 0; i < 2; i++) begin
         s2_acc[i] = (52'(s1_ar_ff[i]) <<< GainFrac)
                   + 52'(s1_gp_ff[i][0]) + 52'(s1_gp_ff[i][1])
                   + 52'(s1_gp_ff[i][2]) + 52'(s1_gp_ff[i][3]);
         s2_rnd[i] = (s2_acc[i] + HalfG) >>> GainFrac;
         {s2_ssat[i], s2_s_in[i]} = sat32(66'(s2_rnd[i]));
         s2_cvr[i]   = (65'(s1_cvp_ff[i]) + HalfQ) >>> FRAC_BITS;
         s2_cv_in[i] = CvW'(s2_cvr[i]);
         {s2_dsat[i], s2_d_in[i]} = sat32(66'(s1_tq_ff[i]) - 66'(s2_cv_in[i]));
      end
      s2_flag_in = s1_cmd_ff ? (|s2_dsat) : (|s2_ssat);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s2_cmd_ff  <= s2_cmd_in;
         s2_flag_ff <= s2_flag_in;
         s2_s_ff    <= s2_s_in;
         s2_d_ff    <= s2_d_in;
         s2_cv_ff   <= s2_cv_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: one shared multiplier per component, inertia times the
   // commanded acceleration or inverse inertia times the net force.
   // ------------------------------------------------------------------------
   logic signed [31:0]  s3_op [2];
   logic [31:0]         s3_coef [2];

   logic                s3_cmd_ff, s3_cmd_in;
   logic                s3_flag_ff, s3_flag_in;
   logic signed [63:0]  s3_prod_ff [2];
   logic signed [63:0]  s3_prod_in [2];
   logic signed [CvW-1:0] s3_cv_ff [2];
   logic signed [CvW-1:0] s3_cv_in [2];

   always_comb begin
      s3_cmd_in  = s2_cmd_ff;
      s3_flag_in = s2_flag_ff;
      for (int i = 0; i < 2; i++) begin
         s3_op[i]      = s2_cmd_ff ? s2_d_ff[i] : s2_s_ff[i];
         s3_coef[i]    = s2_cmd_ff ? i_diag[i] : m_diag[i];
         s3_prod_in[i] = 64'(signed'({1'b0, s3_coef[i]})) * 64'(s3_op[i]);
         s3_cv_in[i]   = s2_cv_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s3_cmd_ff  <= s3_cmd_in;
         s3_flag_ff <= s3_flag_in;
         s3_prod_ff <= s3_prod_in;
         s3_cv_ff   <= s3_cv_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: rescale the product; the control law adds the friction term.
   // ------------------------------------------------------------------------
   logic signed [64:0]    s4_r [2];
   logic signed [CvW-1:0] s4_rq [2];
   logic [1:0]            s4_sat;

   logic                s4_cmd_ff, s4_cmd_in;
   logic                s4_flag_ff, s4_flag_in;
   logic signed [31:0]  s4_y_ff [2];
   logic signed [31:0]  s4_y_in [2];

   always_comb begin
      s4_cmd_in = s3_cmd_ff;
      for (int i = 0; i < 2; i++) begin
         s4_r[i]  = (65'(s3_prod_ff[i]) + HalfQ) >>> FRAC_BITS;
         s4_rq[i] = CvW'(s4_r[i]);
         if (s3_cmd_ff) begin
            {s4_sat[i], s4_y_in[i]} = sat32(66'(s4_rq[i]));
         end else begin
            {s4_sat[i], s4_y_in[i]} = sat32(66'(s4_rq[i]) + 66'(s3_cv_ff[i]));
         end
      end
      s4_flag_in = s3_flag_ff || (|s4_sat);
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s4_cmd_ff  <= s4_cmd_in;
         s4_flag_ff <= s4_flag_in;
         s4_y_ff    <= s4_y_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: actuator matrix products.
   // ------------------------------------------------------------------------
   logic                  s5_cmd_ff, s5_cmd_in;
   logic                  s5_flag_ff, s5_flag_in;
   logic signed [31:0]    s5_y_ff [2];
   logic signed [31:0]    s5_y_in [2];
   logic signed [ActW-1:0] s5_pa_ff, s5_pa_in;
   logic signed [ActW-1:0] s5_pb_ff, s5_pb_in;

   always_comb begin
      s5_cmd_in  = s4_cmd_ff;
      s5_flag_in = s4_flag_ff;
      s5_y_in    = s4_y_ff;
      s5_pa_in   = ActW'(signed'({1'b0, KRw})) * ActW'(s4_y_ff[0]);
      s5_pb_in   = ActW'(signed'({1'b0, KR})) * ActW'(s4_y_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s5_cmd_ff  <= s5_cmd_in;
         s5_flag_ff <= s5_flag_in;
         s5_y_ff    <= s5_y_in;
         s5_pa_ff   <= s5_pa_in;
         s5_pb_ff   <= s5_pb_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: wheel torques from the rescaled actuator terms, into the
   // output register. Forward dynamics passes its accelerations through.
   // ------------------------------------------------------------------------
   logic signed [ActW-1:0] s6_a;
   logic signed [ActW-1:0] s6_b;
   logic                   s6_sat_r;
   logic                   s6_sat_l;
   logic signed [31:0]     s6_right;
   logic signed [31:0]     s6_left;

   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   always_comb begin
      s6_a = (s5_pa_ff + HalfA) >>> FRAC_BITS;
      s6_b = (s5_pb_ff + HalfA) >>> FRAC_BITS;
      {s6_sat_r, s6_right} = sat32(66'(s6_b) + 66'(s6_a));
      {s6_sat_l, s6_left}  = sat32(66'(s6_b) - 66'(s6_a));
      if (s5_cmd_ff) begin
         rsp_word_in.result_first  = s5_y_ff[0];
         rsp_word_in.result_second = s5_y_ff[1];
         rsp_word_in.saturated     = s5_flag_ff;
      end else begin
         rsp_word_in.result_first  = s6_right;
         rsp_word_in.result_second = s6_left;
         rsp_word_in.saturated     = s5_flag_ff || s6_sat_r || s6_sat_l;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

>>> rtl/ddct_checker.sv
// ----------------------------------------------------------------------------
// Computed-torque port checker
// Watches the ports of the unit for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module ddct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input ddct_pkg::req_word_type          req_word,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input ddct_pkg::rsp_word_type          rsp_word,
   input logic                            csr_valid,
   input logic                            csr_ready
);
   import ddct_pkg::*;

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   // A stalled request word holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("stalled request word changed");

   // Requests are only held off while a valid response word is stalled at the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // Configuration writes are never refused.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind diff_drive_computed_torque ddct_checker u_ddct_checker (.*);
